// File: rtl/tilt_pd_to_stepper_pulses_core_macros.svh
// Assertion macros used by the controller RTL.
`ifndef TILT_PD_TO_STEPPER_PULSES_CORE_MACROS_SVH
`define TILT_PD_TO_STEPPER_PULSES_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPSP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tpsp_pkg.sv
package tpsp_pkg;

   localparam int PeriodBitsDef = 16;
   localparam int GainW   = 16;
   localparam int ScaleW  = 32;
   localparam int AngleW  = 16;
   localparam int ErrW    = 17;
   localparam int SumW    = 32;
   localparam int CmdW    = 16;
   localparam int OperW   = 33;
   localparam int ProdW   = 50;
   localparam int AccW    = 51;
   localparam int SpdW    = 34;
   localparam int NumW    = 33;
   localparam int DenW    = 17;
   localparam int DivCntW = 6;
   localparam int OutPerW = 16;
   localparam int AddrW   = 4;
   localparam int DataW   = 32;

   localparam logic [GainW-1:0]  Sin60Q16     = 16'd56756;
   localparam logic [GainW-1:0]  PropGainRst  = 16'd4751;
   localparam logic [GainW-1:0]  DerivGainRst = 16'd4424;
   localparam logic [GainW-1:0]  IntegGainRst = 16'd0;
   localparam logic [ScaleW-1:0] ScaleRst     = 32'd6400;
   localparam int                ResetPeriod  = 500;

   // Datapath operations.
   localparam logic [3:0] OP_NOP     = 4'd0;
   localparam logic [3:0] OP_CAPTURE = 4'd1;
   localparam logic [3:0] OP_MUL     = 4'd2;
   localparam logic [3:0] OP_ACC     = 4'd3;
   localparam logic [3:0] OP_VOUT    = 4'd4;
   localparam logic [3:0] OP_WSET    = 4'd5;
   localparam logic [3:0] OP_WPUT    = 4'd6;
   localparam logic [3:0] OP_TICK    = 4'd7;
   localparam logic [3:0] OP_PUBLISH = 4'd8;

   // Multiplier terms.
   localparam logic [1:0] TERM_P     = 2'd0;
   localparam logic [1:0] TERM_D     = 2'd1;
   localparam logic [1:0] TERM_I     = 2'd2;
   localparam logic [1:0] TERM_CROSS = 2'd3;

   // Register indexes.
   localparam logic [1:0] REG_PROP  = 2'd0;
   localparam logic [1:0] REG_DERIV = 2'd1;
   localparam logic [1:0] REG_INTEG = 2'd2;
   localparam logic [1:0] REG_SCALE = 2'd3;

   typedef struct packed {
      logic [3:0] op;
      logic       axis;
      logic [1:0] term;
      logic [1:0] wheel;
   } tpsp_cmd_type;

   typedef struct packed {
      logic div_done;
   } tpsp_sts_type;

   typedef struct packed {
      logic [GainW-1:0]  prop_gain;
      logic [GainW-1:0]  deriv_gain;
      logic [GainW-1:0]  integ_gain;
      logic [ScaleW-1:0] period_scale;
   } tpsp_cfg_type;

   function automatic logic signed [SumW-1:0] sat_sum(input logic signed [SumW-1:0] a,
                                                      input logic signed [ErrW-1:0] e);
      logic [SumW:0] s;
      s = {a[SumW-1], a} + {{(SumW+1-ErrW){e[ErrW-1]}}, e};
      if (s[SumW] != s[SumW-1]) begin
         sat_sum = s[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end else begin
         sat_sum = s[SumW-1:0];
      end
   endfunction

endpackage

// File: rtl/tpsp_div.sv
module tpsp_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [tpsp_pkg::NumW-1:0] num,
   input  logic [tpsp_pkg::DenW-1:0] den,
   output logic [tpsp_pkg::NumW-1:0] quot,
   output logic                     done
);
   import tpsp_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic [DenW:0]     rem_ff, rem_in;
   logic [NumW-1:0]   q_ff, q_in;
   logic [DenW:0]     rem_sh;
   logic              ge;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      rem_sh  = {rem_ff[DenW-1:0], q_ff[NumW-1]};
      ge      = rem_sh >= {1'b0, den};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DivCntW'(NumW);
         rem_in  = '0;
         q_in    = num;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sh - {1'b0, den} : rem_sh;
         q_in    = {q_ff[NumW-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == DivCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign quot = q_ff;
   assign done = done_ff;

endmodule

// File: rtl/tpsp_dp.sv
module tpsp_dp #(
   parameter int PERIOD_BITS = tpsp_pkg::PeriodBitsDef
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tpsp_pkg::tpsp_cmd_type            cmd,
   output tpsp_pkg::tpsp_sts_type            sts,
   input  tpsp_pkg::tpsp_cfg_type            cfg,
   input  logic signed [tpsp_pkg::AngleW-1:0] pitch_angle,
   input  logic signed [tpsp_pkg::AngleW-1:0] roll_angle,
   output logic [2:0]                        out_pulse,
   output logic [2:0]                        out_dir,
   output logic [tpsp_pkg::OutPerW-1:0]      out_period [3],
   output logic signed [tpsp_pkg::CmdW-1:0]  out_vx,
   output logic signed [tpsp_pkg::CmdW-1:0]  out_vy
);
   import tpsp_pkg::*;

   localparam logic [PERIOD_BITS-1:0] PMax = {PERIOD_BITS{1'b1}};

   logic signed [ErrW-1:0]  e_ff [2], e_in [2];
   logic signed [ErrW-1:0]  prev_ff [2], prev_in [2];
   logic signed [SumW-1:0]  sum_ff [2], sum_in [2];
   logic signed [CmdW-1:0]  v_ff [2], v_in [2];
   logic signed [AccW-1:0]  acc_ff, acc_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic [PERIOD_BITS-1:0]  period_ff [3], period_in [3];
   logic [PERIOD_BITS-1:0]  count_ff [3], count_in [3];
   logic [2:0]              dir_ff, dir_in;
   logic [2:0]              pulse_ff, pulse_in;
   logic                    zero_ff, zero_in;
   logic [2:0]              opulse_ff, opulse_in;
   logic [2:0]              odir_ff, odir_in;
   logic [OutPerW-1:0]      oper_ff [3], oper_in [3];
   logic signed [CmdW-1:0]  ovx_ff, ovx_in, ovy_ff, ovy_in;

   logic signed [GainW:0]   mul_a;
   logic signed [OperW-1:0] mul_b;
   logic signed [ErrW:0]    diff;
   logic signed [AccW-1:0]  rnd, shv;
   logic                    fits;
   logic signed [CmdW-1:0]  vsat;
   logic signed [SpdW-1:0]  half, skew, tsum, spd;
   logic [DenW-1:0]         mag;
   logic [NumW-1:0]         div_num, quot;
   logic                    div_done;
   logic [PERIOD_BITS-1:0]  per_clamp;
   logic [PERIOD_BITS-1:0]  cnt1 [3];

   always_comb begin
      diff = {prev_ff[cmd.axis][ErrW-1], prev_ff[cmd.axis]}
           - {e_ff[cmd.axis][ErrW-1], e_ff[cmd.axis]};
      unique case (cmd.term)
         TERM_P: begin
            mul_a = {1'b0, cfg.prop_gain};
            mul_b = OperW'(e_ff[cmd.axis]);
         end
         TERM_D: begin
            mul_a = {1'b0, cfg.deriv_gain};
            mul_b = OperW'(diff);
         end
         TERM_I: begin
            mul_a = {1'b0, cfg.integ_gain};
            mul_b = OperW'(sum_ff[cmd.axis]);
         end
         TERM_CROSS: begin
            mul_a = {1'b0, Sin60Q16};
            mul_b = OperW'(v_ff[1]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      rnd  = acc_ff + AccW'(8192);
      shv  = rnd >>> 14;
      fits = (&shv[AccW-1:CmdW-1]) | ~(|shv[AccW-1:CmdW-1]);
      vsat = fits ? shv[CmdW-1:0]
                  : (shv[AccW-1] ? {1'b1, {(CmdW-1){1'b0}}} : {1'b0, {(CmdW-1){1'b1}}});

      // Wheel kinematics: a = vx, b and c = -vx/2 -/+ sin60 * vy.
      half  = SpdW'(0) - (SpdW'(v_ff[0]) <<< 15);
      skew  = prod_ff[SpdW-1:0];
      unique case (cmd.wheel)
         2'd1:    tsum = half - skew + SpdW'(32768);
         2'd2:    tsum = half + skew + SpdW'(32768);
         default: tsum = '0;
      endcase
      spd = (cmd.wheel == 2'd0) ? SpdW'(v_ff[0]) : (tsum >>> 16);
      mag = spd[SpdW-1] ? DenW'(SpdW'(0) - spd) : DenW'(spd);
      div_num = NumW'(cfg.period_scale) + NumW'(mag) - NumW'(1);

      if (quot == '0) begin
         per_clamp = PERIOD_BITS'(1);
      end else if (quot > NumW'(PMax)) begin
         per_clamp = PMax;
      end else begin
         per_clamp = PERIOD_BITS'(quot);
      end

      for (int w = 0; w < 3; w++) begin
         cnt1[w] = (count_ff[w] != PMax) ? count_ff[w] + 1'b1 : count_ff[w];
      end
   end

   always_comb begin
      e_in      = e_ff;
      prev_in   = prev_ff;
      sum_in    = sum_ff;
      v_in      = v_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      period_in = period_ff;
      count_in  = count_ff;
      dir_in    = dir_ff;
      pulse_in  = pulse_ff;
      zero_in   = zero_ff;
      opulse_in = opulse_ff;
      odir_in   = odir_ff;
      oper_in   = oper_ff;
      ovx_in    = ovx_ff;
      ovy_in    = ovy_ff;
      unique case (cmd.op)
         OP_CAPTURE: begin
            e_in[0]   = ErrW'(0) - ErrW'(pitch_angle);
            e_in[1]   = ErrW'(0) - ErrW'(roll_angle);
            sum_in[0] = sat_sum(sum_ff[0], e_in[0]);
            sum_in[1] = sat_sum(sum_ff[1], e_in[1]);
            acc_in    = '0;
            pulse_in  = '0;
         end
         OP_MUL: prod_in = mul_a * mul_b;
         OP_ACC: acc_in = acc_ff + AccW'(prod_ff);
         OP_VOUT: begin
            v_in[cmd.axis]    = vsat;
            prev_in[cmd.axis] = e_ff[cmd.axis];
            acc_in            = '0;
         end
         OP_WSET: begin
            dir_in[cmd.wheel] = ~spd[SpdW-1];
            zero_in           = (spd == '0);
         end
         OP_WPUT: begin
            if (zero_ff) begin
               period_in[cmd.wheel] = '0;
               count_in[cmd.wheel]  = '0;
            end else begin
               period_in[cmd.wheel] = per_clamp;
            end
         end
         OP_TICK: begin
            for (int w = 0; w < 3; w++) begin
               pulse_in[w] = 1'b0;
               if (period_ff[w] == '0) begin
                  count_in[w] = '0;
               end else if (cnt1[w] >= period_ff[w]) begin
                  pulse_in[w] = 1'b1;
                  count_in[w] = '0;
               end else begin
                  count_in[w] = cnt1[w];
               end
            end
         end
         OP_PUBLISH: begin
            opulse_in = pulse_ff;
            odir_in   = dir_ff;
            for (int w = 0; w < 3; w++) begin
               oper_in[w] = OutPerW'(period_ff[w]);
            end
            ovx_in = v_ff[0];
            ovy_in = v_ff[1];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 2; a++) begin
            prev_ff[a] <= '0;
            sum_ff[a]  <= '0;
            v_ff[a]    <= '0;
         end
         for (int w = 0; w < 3; w++) begin
            period_ff[w] <= PERIOD_BITS'(ResetPeriod);
            count_ff[w]  <= '0;
         end
         dir_ff   <= '1;
         pulse_ff <= '0;
      end else begin
         prev_ff   <= prev_in;
         sum_ff    <= sum_in;
         v_ff      <= v_in;
         period_ff <= period_in;
         count_ff  <= count_in;
         dir_ff    <= dir_in;
         pulse_ff  <= pulse_in;
      end
      e_ff      <= e_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      zero_ff   <= zero_in;
      opulse_ff <= opulse_in;
      odir_ff   <= odir_in;
      oper_ff   <= oper_in;
      ovx_ff    <= ovx_in;
      ovy_ff    <= ovy_in;
   end

   tpsp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == OP_WSET),
      .num   (div_num),
      .den   (mag),
      .quot  (quot),
      .done  (div_done)
   );

   assign sts.div_done = div_done;
   assign out_pulse    = opulse_ff;
   assign out_dir      = odir_ff;
   assign out_period   = oper_ff;
   assign out_vx       = ovx_ff;
   assign out_vy       = ovy_ff;

endmodule

// File: rtl/tpsp_ctrl.sv
`include "tilt_pd_to_stepper_pulses_core_macros.svh"

module tpsp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_type,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tpsp_pkg::tpsp_cmd_type cmd,
   input  tpsp_pkg::tpsp_sts_type sts
);
   import tpsp_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_TICK  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_ACC   = 4'd3;
   localparam logic [3:0] S_VOUT  = 4'd4;
   localparam logic [3:0] S_CROSS = 4'd5;
   localparam logic [3:0] S_WSET  = 4'd6;
   localparam logic [3:0] S_WDIV  = 4'd7;
   localparam logic [3:0] S_WPUT  = 4'd8;
   localparam logic [3:0] S_PUB   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       axis_ff, axis_in;
   logic [1:0] term_ff, term_in;
   logic [1:0] wheel_ff, wheel_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      term_in   = term_ff;
      wheel_in  = wheel_ff;
      cmd.op    = OP_NOP;
      cmd.axis  = axis_ff;
      cmd.term  = term_ff;
      cmd.wheel = wheel_ff;
      unique case (state_ff)
         S_IDLE: begin
            axis_in  = 1'b0;
            term_in  = TERM_P;
            wheel_in = 2'd0;
            if (req_valid) begin
               if (req_type) begin
                  state_in = S_TICK;
               end else begin
                  cmd.op   = OP_CAPTURE;
                  state_in = S_MUL;
               end
            end
         end
         S_TICK: begin
            cmd.op   = OP_TICK;
            state_in = S_PUB;
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACC;
            if (term_ff == TERM_I) begin
               state_in = S_VOUT;
            end else begin
               term_in  = term_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_VOUT: begin
            cmd.op  = OP_VOUT;
            term_in = TERM_P;
            if (axis_ff) begin
               state_in = S_CROSS;
            end else begin
               axis_in  = 1'b1;
               state_in = S_MUL;
            end
         end
         S_CROSS: begin
            cmd.op   = OP_MUL;
            cmd.term = TERM_CROSS;
            state_in = S_WSET;
         end
         S_WSET: begin
            cmd.op   = OP_WSET;
            state_in = S_WDIV;
         end
         S_WDIV: begin
            if (sts.div_done) begin
               state_in = S_WPUT;
            end
         end
         S_WPUT: begin
            cmd.op = OP_WPUT;
            if (wheel_ff == 2'd2) begin
               state_in = S_PUB;
            end else begin
               wheel_in = wheel_ff + 1'b1;
               state_in = S_WSET;
            end
         end
         S_PUB: begin
            if (out_free) begin
               cmd.op   = OP_PUBLISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = (cmd.op == OP_PUBLISH) | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         term_ff      <= TERM_P;
         wheel_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         term_ff      <= term_in;
         wheel_ff     <= wheel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `TPSP_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.op == OP_PUBLISH, !(rsp_valid_ff && rsp_stall), "result overwritten while pending")
   `TPSP_ASSERT_NEXT(a_div_wait, clock, reset, state_ff == S_WDIV && !sts.div_done, state_ff == S_WDIV, "left divide wait early")
   `TPSP_ASSERT_NEXT(a_tick_path, clock, reset, state_ff == S_IDLE && req_valid && req_type, state_ff == S_TICK, "tick not dispatched")

endmodule

// File: rtl/tilt_pd_to_stepper_pulses_core.sv
// Channel    Handshake                    Payload
// req        req_valid / req_stall        req_type, req_pitch_angle, req_roll_angle
// rsp        rsp_valid / rsp_stall        step pulses, directions, periods, cmd_vx, cmd_vy
// csr        csr_psel / csr_penable       csr_paddr, csr_pwdata, csr_prdata
//
// A timer tick runs through the TICK and PUB states to a registered result.
// An orientation sample runs the PID multiply-accumulate for both axes, the
// cross term and, per wheel, a wait on the shared 33-step restoring divider.
// Reset is synchronous and active high; no clearing pass is needed afterward.
// A finished result waits in the output register while rsp_stall is high, and
// the next beat can be accepted meanwhile; only publishing waits on it.
module tilt_pd_to_stepper_pulses_core #(
   parameter int PERIOD_BITS = tpsp_pkg::PeriodBitsDef
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic signed [tpsp_pkg::AngleW-1:0]  req_pitch_angle,
   input  logic signed [tpsp_pkg::AngleW-1:0]  req_roll_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_step_pulse_a,
   output logic                                rsp_step_pulse_b,
   output logic                                rsp_step_pulse_c,
   output logic                                rsp_dir_a,
   output logic                                rsp_dir_b,
   output logic                                rsp_dir_c,
   output logic [tpsp_pkg::OutPerW-1:0]        rsp_period_a,
   output logic [tpsp_pkg::OutPerW-1:0]        rsp_period_b,
   output logic [tpsp_pkg::OutPerW-1:0]        rsp_period_c,
   output logic signed [tpsp_pkg::CmdW-1:0]    rsp_cmd_vx,
   output logic signed [tpsp_pkg::CmdW-1:0]    rsp_cmd_vy,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tpsp_pkg::AddrW-1:0]          csr_paddr,
   input  logic [tpsp_pkg::DataW-1:0]          csr_pwdata,
   output logic [tpsp_pkg::DataW-1:0]          csr_prdata,
   output logic                                csr_pready
);
   import tpsp_pkg::*;

   tpsp_cfg_type cfg_ff, cfg_in;
   tpsp_cmd_type cmd;
   tpsp_sts_type sts;
   logic [1:0]   reg_idx;
   logic         wr_en;
   logic [2:0]   pulse, dir;
   logic [OutPerW-1:0] period [3];

   // Registers sit at byte addresses 0, 4, 8 and 12; the low address bits
   // are not decoded.
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      unique case (reg_idx)
         REG_PROP:  csr_prdata = DataW'(cfg_ff.prop_gain);
         REG_DERIV: csr_prdata = DataW'(cfg_ff.deriv_gain);
         REG_INTEG: csr_prdata = DataW'(cfg_ff.integ_gain);
         REG_SCALE: csr_prdata = DataW'(cfg_ff.period_scale);
         default:   csr_prdata = '0;
      endcase
      if (wr_en) begin
         unique case (reg_idx)
            REG_PROP:  cfg_in.prop_gain    = csr_pwdata[GainW-1:0];
            REG_DERIV: cfg_in.deriv_gain   = csr_pwdata[GainW-1:0];
            REG_INTEG: cfg_in.integ_gain   = csr_pwdata[GainW-1:0];
            REG_SCALE: cfg_in.period_scale = csr_pwdata[ScaleW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain    <= PropGainRst;
         cfg_ff.deriv_gain   <= DerivGainRst;
         cfg_ff.integ_gain   <= IntegGainRst;
         cfg_ff.period_scale <= ScaleRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The controller sequences the timer tick, the PID multiply-accumulate, the kinematics and
   // the per-wheel divisions; the datapath holds the arithmetic and the control-loop state.
   tpsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   tpsp_dp #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .cfg         (cfg_ff),
      .pitch_angle (req_pitch_angle),
      .roll_angle  (req_roll_angle),
      .out_pulse   (pulse),
      .out_dir     (dir),
      .out_period  (period),
      .out_vx      (rsp_cmd_vx),
      .out_vy      (rsp_cmd_vy)
   );

   assign rsp_step_pulse_a = pulse[0];
   assign rsp_step_pulse_b = pulse[1];
   assign rsp_step_pulse_c = pulse[2];
   assign rsp_dir_a        = dir[0];
   assign rsp_dir_b        = dir[1];
   assign rsp_dir_c        = dir[2];
   assign rsp_period_a     = period[0];
   assign rsp_period_b     = period[1];
   assign rsp_period_c     = period[2];

endmodule
